// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the parser modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Assert that a property holds on every clock while out of reset.
`define PBSP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Assert that an expression is never true while out of reset.
`define PBSP_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`endif

// ===== hdl/pbsp_pkg.sv =====
// Types, constants and helpers of the pcapng block stream parser.
package pbsp_pkg;
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam logic [23:0] MAX_CAP_RESET = 24'd262144;
	localparam logic [31:0] SHB_TYPE_WORD = 32'h0A0D0D0A;
	localparam logic [31:0] EPB_TYPE_WORD = 32'd6;
	localparam logic [31:0] IDB_TYPE_WORD = 32'd1;
	localparam logic [31:0] MAGIC_LE_RAW = 32'h1A2B3C4D;
	localparam logic [31:0] MAGIC_BE_RAW = 32'h4D3C2B1A;
	localparam logic [31:0] MIN_BLOCK = 32'd12;
	localparam logic [31:0] EPB_HDR_LEN = 32'd20;
	localparam logic [31:0] IDB_HDR_LEN = 32'd8;
	localparam logic [31:0] SHB_MIN_LEN = 32'd28;
	localparam logic [0:0] OP_BYTE = 1'b0;
	localparam logic [0:0] OP_EOS = 1'b1;
	localparam logic [1:0] K_DATA = 2'd0;
	localparam logic [1:0] K_PKT = 2'd1;
	localparam logic [1:0] K_IFACE = 2'd2;
	localparam logic [1:0] K_STOP = 2'd3;
	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_EOF = 3'd1;
	localparam logic [2:0] ST_IO = 3'd2;
	localparam logic [2:0] ST_FMT = 3'd3;
	localparam logic [2:0] ST_SHB = 3'd4;

	typedef enum logic [4:0] {
		P_SHB_HEAD, P_SHB_SKIP, P_SHB_TRAIL,
		P_BLK_TYPE, P_LEN_EPB, P_LEN_IDB, P_LEN_OTH,
		P_EPB_HDR, P_EPB_DATA, P_SKIP_EPB, P_TRAIL_EPB,
		P_IDB_HDR, P_OPT_HDR, P_OPT_VAL, P_SKIP_IDB, P_TRAIL_IDB,
		P_SKIP_OTH, P_TRAIL_OTH
	} phase_t;

	typedef struct packed {
		logic       opcode;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  data_byte_out;
		logic        data_last;
		logic [31:0] iface_id;
		logic [63:0] timestamp;
		logic [23:0] cap_bytes;
		logic [31:0] wire_len;
		logic [15:0] link_code;
		logic [31:0] snaplen;
		logic [2:0]  status;
	} out_item_t;

	function automatic logic [31:0] swap32(input logic [31:0] v);
		return {v[7:0], v[15:8], v[23:16], v[31:24]};
	endfunction

	function automatic logic [15:0] swap16(input logic [15:0] v);
		return {v[7:0], v[15:8]};
	endfunction
endpackage

// ===== hdl/pbsp_front.sv =====
// Front end: accepts request items and holds them in a short queue.
module pbsp_front #(
	parameter int unsigned DEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  pbsp_pkg::in_item_t in_data,
	output logic              q_valid,
	input  logic              q_pop,
	output pbsp_pkg::in_item_t q_data
);
	import pbsp_pkg::*;
	`include "assert_macros.svh"

	localparam int unsigned PW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	in_item_t mem [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic push, pop;

	assign in_ready = (count_q != CW'(DEPTH));
	assign q_valid  = (count_q != '0);
	assign q_data   = mem[rd_ptr_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_pop && q_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`PBSP_NEVER(a_count_over, count_q > CW'(DEPTH), "queue count beyond depth")
endmodule

// ===== hdl/pbsp_back.sv =====
// Back end: parses queued bytes and registers result records.
module pbsp_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	output logic                q_pop,
	input  pbsp_pkg::in_item_t  q_data,
	input  logic [23:0]         max_cap,
	output logic                out_valid,
	input  logic                out_ready,
	output pbsp_pkg::out_item_t out_data
);
	import pbsp_pkg::*;
	`include "assert_macros.svh"

	phase_t phase_q, n_phase;
	logic [23:0] fp_q, n_fp;
	logic [31:0] wb_q, n_wb;
	logic swap_q, n_swap;
	logic [31:0] blen_q, n_blen, bl_q, n_bl;
	logic [31:0] piface_q, n_piface;
	logic [63:0] ptime_q, n_ptime;
	logic [31:0] pcap_q, n_pcap, porig_q, n_porig;
	logic [15:0] ocode_q, n_ocode, olen_q, n_olen;
	logic [15:0] ilink_q, n_ilink;
	logic [31:0] isnap_q, n_isnap, itotal_q, n_itotal;
	logic stopped_q, n_stopped;
	logic res_valid;
	out_item_t res, out_q;
	logic out_valid_q;

	logic [1:0]  k;
	logic        full;
	logic [31:0] v32, body, blen_sw, cap_pad;
	logic [15:0] lo16, hi16;
	logic [17:0] opad;

	assign q_pop     = q_valid && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		n_phase = phase_q; n_fp = fp_q; n_wb = wb_q; n_swap = swap_q;
		n_blen = blen_q; n_bl = bl_q; n_piface = piface_q; n_ptime = ptime_q;
		n_pcap = pcap_q; n_porig = porig_q; n_ocode = ocode_q; n_olen = olen_q;
		n_ilink = ilink_q; n_isnap = isnap_q; n_itotal = itotal_q;
		n_stopped = stopped_q;
		res_valid = 1'b0;
		res = '0;
		k = fp_q[1:0];
		full = (k == 2'd3);
		body = '0;
		blen_sw = '0;
		cap_pad = '0;
		opad = '0;
		if (k == 2'd0) begin
			n_wb = {24'd0, q_data.data_byte};
		end else begin
			n_wb = wb_q | ({24'd0, q_data.data_byte} << {k, 3'b000});
		end
		v32  = swap_q ? swap32(n_wb) : n_wb;
		lo16 = swap_q ? swap16(n_wb[15:0]) : n_wb[15:0];
		hi16 = swap_q ? swap16(n_wb[31:16]) : n_wb[31:16];

		if (q_data.opcode == OP_EOS) begin
			n_wb = wb_q;
			res_valid = 1'b1;
			res.kind = K_STOP;
			n_stopped = 1'b1;
			if (phase_q == P_SHB_HEAD || phase_q == P_SHB_SKIP || phase_q == P_SHB_TRAIL) begin
				res.status = ST_SHB;
			end else if (phase_q == P_BLK_TYPE) begin
				res.status = (fp_q == '0) ? ST_EOF : ST_IO;
			end else begin
				res.status = ST_FMT;
			end
		end else begin
			case (phase_q)
				P_SHB_HEAD: begin
					n_fp = fp_q + 1'b1;
					if (fp_q == 24'd3 && n_wb != SHB_TYPE_WORD) begin
						res_valid = 1'b1; res.status = ST_SHB;
					end
					if (fp_q == 24'd7) begin
						n_blen = n_wb;
					end
					if (fp_q == 24'd11) begin
						blen_sw = (n_wb == MAGIC_BE_RAW) ? swap32(blen_q) : blen_q;
						n_blen = blen_sw;
						if (n_wb == MAGIC_LE_RAW) begin
							n_swap = 1'b0;
						end else if (n_wb == MAGIC_BE_RAW) begin
							n_swap = 1'b1;
						end
						if ((n_wb != MAGIC_LE_RAW && n_wb != MAGIC_BE_RAW)
							|| blen_sw < SHB_MIN_LEN) begin
							res_valid = 1'b1; res.status = ST_SHB;
						end
					end
					if (fp_q == 24'd23) begin
						n_bl = blen_q - SHB_MIN_LEN;
						n_fp = '0;
						n_phase = (n_bl != '0) ? P_SHB_SKIP : P_SHB_TRAIL;
					end
				end
				P_SHB_SKIP, P_SKIP_EPB, P_SKIP_IDB, P_SKIP_OTH: begin
					n_bl = bl_q - 1'b1;
					if (n_bl == '0) begin
						n_fp = '0;
						n_phase = phase_t'(phase_q + 5'd1);
					end
				end
				P_SHB_TRAIL, P_TRAIL_EPB, P_TRAIL_IDB, P_TRAIL_OTH: begin
					if (!full) begin
						n_fp = fp_q + 1'b1;
					end else if (v32 != blen_q) begin
						res_valid = 1'b1;
						res.status = (phase_q == P_SHB_TRAIL) ? ST_SHB : ST_FMT;
					end else begin
						n_fp = '0;
						n_phase = P_BLK_TYPE;
						if (phase_q == P_TRAIL_EPB) begin
							res_valid = 1'b1;
							res.kind = K_PKT;
							res.iface_id = piface_q;
							res.timestamp = ptime_q;
							res.cap_bytes = pcap_q[23:0];
							res.wire_len = porig_q;
						end else if (phase_q == P_TRAIL_IDB) begin
							res_valid = 1'b1;
							res.kind = K_IFACE;
							res.iface_id = itotal_q;
							res.link_code = ilink_q;
							res.snaplen = isnap_q;
							n_itotal = itotal_q + 1'b1;
						end
					end
				end
				P_BLK_TYPE: begin
					if (!full) begin
						n_fp = fp_q + 1'b1;
					end else begin
						n_fp = '0;
						n_phase = (v32 == EPB_TYPE_WORD) ? P_LEN_EPB :
							(v32 == IDB_TYPE_WORD) ? P_LEN_IDB : P_LEN_OTH;
					end
				end
				P_LEN_EPB, P_LEN_IDB, P_LEN_OTH: begin
					if (!full) begin
						n_fp = fp_q + 1'b1;
					end else begin
						n_blen = v32;
						body = v32 - MIN_BLOCK;
						n_fp = '0;
						if (v32 < MIN_BLOCK) begin
							res_valid = 1'b1; res.status = ST_FMT;
						end else if (phase_q == P_LEN_EPB) begin
							if (body < EPB_HDR_LEN) begin
								res_valid = 1'b1; res.status = ST_FMT;
							end
							n_phase = P_EPB_HDR;
						end else if (phase_q == P_LEN_IDB) begin
							if (body < IDB_HDR_LEN) begin
								res_valid = 1'b1; res.status = ST_FMT;
							end
							n_phase = P_IDB_HDR;
						end else begin
							n_bl = body;
							n_phase = (body != '0) ? P_SKIP_OTH : P_TRAIL_OTH;
						end
					end
				end
				P_EPB_HDR: begin
					n_fp = fp_q + 1'b1;
					if (full) begin
						case (fp_q[4:0])
							5'd3: n_piface = v32;
							5'd7: n_ptime = {v32, 32'd0};
							5'd11: n_ptime = {ptime_q[63:32], v32};
							5'd15: n_pcap = v32;
							default: n_porig = v32;
						endcase
						if (fp_q == 24'd19) begin
							body = blen_q - MIN_BLOCK - EPB_HDR_LEN;
							cap_pad = (pcap_q + 32'd3) & ~32'd3;
							n_bl = body - pcap_q;
							n_fp = '0;
							if (pcap_q > 32'hFFFFFFFC || cap_pad > body
								|| pcap_q > {8'd0, max_cap}) begin
								res_valid = 1'b1; res.status = ST_FMT;
							end else if (pcap_q != '0) begin
								n_phase = P_EPB_DATA;
							end else begin
								n_phase = (n_bl != '0) ? P_SKIP_EPB : P_TRAIL_EPB;
							end
						end
					end
				end
				P_EPB_DATA: begin
					res_valid = 1'b1;
					res.kind = K_DATA;
					res.data_byte_out = q_data.data_byte;
					n_fp = fp_q + 1'b1;
					if ({8'd0, n_fp} >= pcap_q) begin
						res.data_last = 1'b1;
						n_fp = '0;
						n_phase = (bl_q != '0) ? P_SKIP_EPB : P_TRAIL_EPB;
					end
				end
				P_IDB_HDR: begin
					n_fp = fp_q + 1'b1;
					if (full) begin
						if (fp_q == 24'd3) begin
							n_ilink = lo16;
						end else begin
							n_isnap = v32;
							n_bl = blen_q - MIN_BLOCK - IDB_HDR_LEN;
							n_fp = '0;
							n_phase = (n_bl >= 32'd4) ? P_OPT_HDR :
								(n_bl != '0) ? P_SKIP_IDB : P_TRAIL_IDB;
						end
					end
				end
				P_OPT_HDR: begin
					n_bl = bl_q - 1'b1;
					n_fp = fp_q + 1'b1;
					if (full) begin
						n_ocode = lo16;
						n_olen = hi16;
						opad = ({2'd0, hi16} + 18'd3) & ~18'd3;
						n_fp = '0;
						if ({14'd0, opad} > n_bl) begin
							res_valid = 1'b1; res.status = ST_FMT;
						end else if (opad != '0) begin
							n_phase = P_OPT_VAL;
						end else if (lo16 == '0 || n_bl < 32'd4) begin
							n_phase = (n_bl != '0) ? P_SKIP_IDB : P_TRAIL_IDB;
						end else begin
							n_phase = P_OPT_HDR;
						end
					end
				end
				P_OPT_VAL: begin
					n_bl = bl_q - 1'b1;
					n_fp = fp_q + 1'b1;
					opad = ({2'd0, olen_q} + 18'd3) & ~18'd3;
					if (n_fp >= {6'd0, opad}) begin
						n_fp = '0;
						if (ocode_q == '0 || n_bl < 32'd4) begin
							n_phase = (n_bl != '0) ? P_SKIP_IDB : P_TRAIL_IDB;
						end else begin
							n_phase = P_OPT_HDR;
						end
					end
				end
				default: begin
					res_valid = 1'b1; res.status = ST_FMT;
				end
			endcase
			if (res_valid && res.status != ST_OK) begin
				res.kind = K_STOP;
				n_stopped = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= P_SHB_HEAD;
		end else if (q_pop && !stopped_q) begin
			phase_q <= n_phase;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fp_q <= '0; wb_q <= '0; swap_q <= 1'b0; blen_q <= '0; bl_q <= '0;
			piface_q <= '0; ptime_q <= '0; pcap_q <= '0; porig_q <= '0;
			ocode_q <= '0; olen_q <= '0; ilink_q <= '0; isnap_q <= '0;
			itotal_q <= '0; stopped_q <= 1'b0; out_valid_q <= 1'b0;
		end else begin
			if (q_pop && !stopped_q) begin
				fp_q <= n_fp; wb_q <= n_wb; swap_q <= n_swap; blen_q <= n_blen;
				bl_q <= n_bl; piface_q <= n_piface; ptime_q <= n_ptime;
				pcap_q <= n_pcap; porig_q <= n_porig; ocode_q <= n_ocode;
				olen_q <= n_olen; ilink_q <= n_ilink; isnap_q <= n_isnap;
				itotal_q <= n_itotal; stopped_q <= n_stopped;
			end
			if (q_pop && !stopped_q && res_valid) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && !stopped_q && res_valid) begin
			out_q <= res;
		end
	end

	`PBSP_ASSERT(a_stop_record, $rose(stopped_q) |-> out_valid_q && out_q.kind == K_STOP, "stop without record")
	`PBSP_NEVER(a_last_kind, out_valid_q && out_q.data_last && out_q.kind != K_DATA, "last on non-data record")
endmodule

// ===== hdl/pcapng_block_stream_parser.sv =====
// Top level of the pcapng block stream parser.
//
// Input channel (in_valid/in_ready/in_data): one request per file byte,
// opcode 0 carries data_byte, opcode 1 marks end of stream.
// Output channel (out_valid/out_ready/out_data): packet data bytes, packet
// completion records, interface records and one final stop record.
// APB port: register 0 (byte address 0) is max_captured_len, 24 bits.
// Throughput: one request per cycle while the queue is not full; the parser
// consumes one queued byte per cycle whenever the output register is free
// or being drained. A request is written into the queue first, and its
// result record is then registered in the output register before it shows
// on out_data; an output stall keeps waiting bytes in the queue.
// Reset empties the queue and clears the parser state and out_valid; the
// register returns to 262144. When the receiver stalls, the output record
// holds, the parser stops, and the input queue fills before in_ready drops.
// After the stop record further requests are accepted and dropped.
module pcapng_block_stream_parser #(
	parameter int unsigned QDEPTH = pbsp_pkg::QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  pbsp_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output pbsp_pkg::out_item_t out_data,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);
	import pbsp_pkg::*;

	logic [23:0] max_cap_q;
	logic q_valid, q_pop;
	in_item_t q_data;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? {8'd0, max_cap_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_cap_q <= MAX_CAP_RESET;
		end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
			max_cap_q <= pwdata[23:0];
		end
	end

	pbsp_front #(.DEPTH(QDEPTH)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.q_valid(q_valid), .q_pop(q_pop), .q_data(q_data)
	);

	pbsp_back u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_pop(q_pop), .q_data(q_data),
		.max_cap(max_cap_q),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);
endmodule

// ===== tb/pcapng_block_stream_parser_tb.sv =====
// Testbench of the pcapng block stream parser: a generated capture stream checked against a parser model.
module pcapng_block_stream_parser_tb;
	import pbsp_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_LIMIT = 3000;

	logic clk = 1'b1;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_data;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	pcapng_block_stream_parser i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	in_item_t byte_q[$];
	out_item_t record_q[$];
	int errors = 0;
	int bytes_sent = 0;
	int n_data = 0, n_pkt = 0, n_iface = 0, n_recs = 0;
	logic [2:0] final_status = ST_OK;
	bit big_endian;
	bit quiet = 0;
	bit in_taken = 0;
	int in_gap = 0, out_gap = 0, hold_left = 0;
	bit hold_done = 0;
	int idle_cycles = 0;

	// parser model state
	logic [23:0] cap_limit;
	phase_t ph;
	logic [31:0] fpos, wbuild, blen, left, p_iface, p_cap, p_orig, i_snap, i_count;
	logic [63:0] p_time;
	logic [15:0] o_code, o_len, i_link;
	bit swapped, halted;

	task automatic model_reset();
		cap_limit = MAX_CAP_RESET;
		ph = P_SHB_HEAD;
		{fpos, wbuild, blen, left, p_iface, p_cap, p_orig, i_snap, i_count} = '0;
		{p_time, o_code, o_len, i_link} = '0;
		swapped = 0;
		halted = 0;
	endtask

	function automatic bit halt(inout out_item_t r, input logic [2:0] st);
		r = '0;
		r.kind = K_STOP;
		r.status = st;
		halted = 1;
		return 1;
	endfunction

	function automatic void skip_or_trail(input phase_t s);
		fpos = 0;
		ph = (left > 0) ? s : phase_t'(s + 1);
	endfunction

	function automatic void next_option();
		if (left >= 4) begin
			fpos = 0;
			ph = P_OPT_HDR;
		end else skip_or_trail(P_SKIP_IDB);
	endfunction

	function automatic bit parse_byte(input in_item_t it, output out_item_t r);
		logic [31:0] b, v32, body, padded;
		logic [15:0] lo16, hi16;
		logic [1:0] k;
		bit full;
		phase_t done;
		r = '0;
		if (halted) return 0;
		if (it.opcode == OP_EOS) begin
			if (ph <= P_SHB_TRAIL) return halt(r, ST_SHB);
			if (ph == P_BLK_TYPE) return halt(r, fpos == 0 ? ST_EOF : ST_IO);
			return halt(r, ST_FMT);
		end
		b = {24'd0, it.data_byte};
		k = fpos[1:0];
		wbuild = (k == 0) ? b : (wbuild | (b << (8 * k)));
		full = (k == 2'd3);
		v32 = swapped ? swap32(wbuild) : wbuild;
		lo16 = swapped ? swap16(wbuild[15:0]) : wbuild[15:0];
		hi16 = swapped ? swap16(wbuild[31:16]) : wbuild[31:16];
		case (ph)
			P_SHB_HEAD: begin
				if (fpos == 3 && wbuild != SHB_TYPE_WORD) return halt(r, ST_SHB);
				if (fpos == 7) blen = wbuild;
				if (fpos == 11) begin
					if (wbuild == MAGIC_LE_RAW) swapped = 0;
					else if (wbuild == MAGIC_BE_RAW) swapped = 1;
					else return halt(r, ST_SHB);
					if (swapped) blen = swap32(blen);
					if (blen < SHB_MIN_LEN) return halt(r, ST_SHB);
				end
				if (fpos == 23) begin
					left = blen - SHB_MIN_LEN;
					skip_or_trail(P_SHB_SKIP);
					return 0;
				end
				fpos++;
				return 0;
			end
			P_SHB_SKIP, P_SKIP_EPB, P_SKIP_IDB, P_SKIP_OTH: begin
				left--;
				if (left == 0) begin
					fpos = 0;
					ph = phase_t'(ph + 1);
				end
				return 0;
			end
			P_SHB_TRAIL, P_TRAIL_EPB, P_TRAIL_IDB, P_TRAIL_OTH: begin
				if (!full) begin
					fpos++;
					return 0;
				end
				if (v32 != blen) return halt(r, ph == P_SHB_TRAIL ? ST_SHB : ST_FMT);
				fpos = 0;
				done = ph;
				ph = P_BLK_TYPE;
				if (done == P_TRAIL_EPB) begin
					r.kind = K_PKT;
					r.iface_id = p_iface;
					r.timestamp = p_time;
					r.cap_bytes = p_cap[23:0];
					r.wire_len = p_orig;
					return 1;
				end
				if (done == P_TRAIL_IDB) begin
					r.kind = K_IFACE;
					r.iface_id = i_count;
					r.link_code = i_link;
					r.snaplen = i_snap;
					i_count++;
					return 1;
				end
				return 0;
			end
			P_BLK_TYPE: begin
				if (!full) begin
					fpos++;
					return 0;
				end
				fpos = 0;
				ph = (v32 == EPB_TYPE_WORD) ? P_LEN_EPB :
					(v32 == IDB_TYPE_WORD) ? P_LEN_IDB : P_LEN_OTH;
				return 0;
			end
			P_LEN_EPB, P_LEN_IDB, P_LEN_OTH: begin
				if (!full) begin
					fpos++;
					return 0;
				end
				blen = v32;
				if (blen < MIN_BLOCK) return halt(r, ST_FMT);
				body = blen - MIN_BLOCK;
				fpos = 0;
				if (ph == P_LEN_EPB) begin
					if (body < EPB_HDR_LEN) return halt(r, ST_FMT);
					ph = P_EPB_HDR;
				end else if (ph == P_LEN_IDB) begin
					if (body < IDB_HDR_LEN) return halt(r, ST_FMT);
					ph = P_IDB_HDR;
				end else begin
					left = body;
					skip_or_trail(P_SKIP_OTH);
				end
				return 0;
			end
			P_EPB_HDR: begin
				if (!full) begin
					fpos++;
					return 0;
				end
				case (fpos)
					3: p_iface = v32;
					7: p_time[63:32] = v32;
					11: p_time[31:0] = v32;
					15: p_cap = v32;
					default: p_orig = v32;
				endcase
				if (fpos != 19) begin
					fpos++;
					return 0;
				end
				body = blen - MIN_BLOCK;
				if (p_cap > 32'hFFFFFFFC) return halt(r, ST_FMT);
				padded = (p_cap + 3) & ~32'd3;
				if (padded > body - EPB_HDR_LEN) return halt(r, ST_FMT);
				if (p_cap > {8'd0, cap_limit}) return halt(r, ST_FMT);
				left = body - EPB_HDR_LEN - p_cap;
				fpos = 0;
				if (p_cap > 0) ph = P_EPB_DATA;
				else skip_or_trail(P_SKIP_EPB);
				return 0;
			end
			P_EPB_DATA: begin
				r.kind = K_DATA;
				r.data_byte_out = b[7:0];
				fpos++;
				if (fpos >= p_cap) begin
					r.data_last = 1'b1;
					skip_or_trail(P_SKIP_EPB);
				end
				return 1;
			end
			P_IDB_HDR: begin
				if (!full) begin
					fpos++;
					return 0;
				end
				if (fpos == 3) begin
					i_link = lo16;
					fpos++;
					return 0;
				end
				i_snap = v32;
				left = blen - MIN_BLOCK - IDB_HDR_LEN;
				next_option();
				return 0;
			end
			P_OPT_HDR: begin
				left--;
				if (!full) begin
					fpos++;
					return 0;
				end
				o_code = lo16;
				o_len = hi16;
				padded = ({16'd0, o_len} + 3) & ~32'd3;
				if (padded > left) return halt(r, ST_FMT);
				fpos = 0;
				if (padded > 0) ph = P_OPT_VAL;
				else if (o_code == 0) skip_or_trail(P_SKIP_IDB);
				else next_option();
				return 0;
			end
			P_OPT_VAL: begin
				left--;
				fpos++;
				padded = ({16'd0, o_len} + 3) & ~32'd3;
				if (fpos >= padded) begin
					if (o_code == 0) skip_or_trail(P_SKIP_IDB);
					else next_option();
				end
				return 0;
			end
			default: return halt(r, ST_FMT);
		endcase
	endfunction

	task automatic report(input string field, input logic [63:0] got, input logic [63:0] want);
		$display("mismatch at %0t: record %0d field %s got %0h expected %0h",
			$realtime, n_recs, field, got, want);
		errors++;
	endtask

	// monitor: predict on each accepted request, check each accepted record
	always @(posedge clk) begin
		out_item_t want, r;
		in_taken <= in_valid && in_ready;
		if (arst_n && out_valid && out_ready) begin
			if (record_q.size() == 0) begin
				report("unexpected record kind", {62'd0, out_data.kind}, 64'd0);
			end else begin
				want = record_q.pop_front();
				if (out_data.kind !== want.kind) report("kind", out_data.kind, want.kind);
				if (out_data.data_byte_out !== want.data_byte_out)
					report("data_byte_out", out_data.data_byte_out, want.data_byte_out);
				if (out_data.data_last !== want.data_last)
					report("data_last", out_data.data_last, want.data_last);
				if (out_data.iface_id !== want.iface_id)
					report("iface_id", out_data.iface_id, want.iface_id);
				if (out_data.timestamp !== want.timestamp)
					report("timestamp", out_data.timestamp, want.timestamp);
				if (out_data.cap_bytes !== want.cap_bytes)
					report("cap_bytes", out_data.cap_bytes, want.cap_bytes);
				if (out_data.wire_len !== want.wire_len)
					report("wire_len", out_data.wire_len, want.wire_len);
				if (out_data.link_code !== want.link_code)
					report("link_code", out_data.link_code, want.link_code);
				if (out_data.snaplen !== want.snaplen)
					report("snaplen", out_data.snaplen, want.snaplen);
				if (out_data.status !== want.status)
					report("status", out_data.status, want.status);
				case (want.kind)
					K_DATA: n_data++;
					K_PKT: n_pkt++;
					K_IFACE: n_iface++;
					default: final_status = want.status;
				endcase
			end
			n_recs++;
		end
		if (arst_n && in_valid && in_ready)
			if (parse_byte(in_data, r)) record_q.push_back(r);
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && !in_taken) begin
		end else if (in_gap > 0) begin
			in_gap--;
			in_valid <= 1'b0;
		end else if (!quiet && byte_q.size() > 0 && $urandom_range(0, 7) == 0) begin
			in_gap = $urandom_range(0, 2);
			in_valid <= 1'b0;
		end else if (byte_q.size() > 0) begin
			in_valid <= 1'b1;
			in_data <= byte_q.pop_front();
		end else begin
			in_valid <= 1'b0;
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (!hold_done && n_recs >= 300) begin
			hold_done = 1;
			hold_left = 90;
			out_ready <= 1'b0;
		end else if (out_gap > 0) begin
			out_gap--;
			out_ready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 5) == 0) begin
			out_gap = $urandom_range(0, 2);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || psel) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout: nothing accepted for %0d cycles", IDLE_LIMIT);
			$display("FAIL pcapng_block_stream_parser");
			$finish;
		end
	end

	task automatic apb_write(input logic [23:0] value);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= 3'd0;
		pwdata <= {8'd0, value};
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		cap_limit = value;
	endtask

	task automatic drain();
		while (byte_q.size() > 0 || in_valid) @(posedge clk);
		while (record_q.size() > 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic put8(input logic [7:0] b);
		byte_q.push_back('{opcode: OP_BYTE, data_byte: b});
		bytes_sent++;
	endtask

	task automatic put16(input logic [15:0] v);
		if (big_endian) begin
			put8(v[15:8]);
			put8(v[7:0]);
		end else begin
			put8(v[7:0]);
			put8(v[15:8]);
		end
	endtask

	task automatic put32(input logic [31:0] v);
		if (big_endian) begin
			put16(v[31:16]);
			put16(v[15:0]);
		end else begin
			put16(v[15:0]);
			put16(v[31:16]);
		end
	endtask

	task automatic put_eos();
		byte_q.push_back('{opcode: OP_EOS, data_byte: 8'($urandom)});
	endtask

	function automatic int pad4(input int n);
		return (n + 3) & ~3;
	endfunction

	task automatic add_section(input int extra);
		put32(SHB_TYPE_WORD);
		put32(28 + extra);
		put32(MAGIC_LE_RAW);
		put32($urandom);
		put32($urandom);
		put32($urandom);
		repeat (extra) put8(8'($urandom));
		put32(28 + extra);
	endtask

	task automatic add_packet(input int cap, input int opt, input bit bad_trailer);
		int total;
		total = 32 + pad4(cap) + opt;
		put32(EPB_TYPE_WORD);
		put32(total);
		put32($urandom);
		put32($urandom);
		put32($urandom);
		put32(cap);
		put32($urandom);
		repeat (pad4(cap) + opt) put8(8'($urandom));
		put32(bad_trailer ? total + 4 : total);
	endtask

	task automatic add_iface(input int nopt, input bit end_opt, input int tail);
		int lens[$];
		int size, n;
		size = tail + (end_opt ? 4 : 0);
		for (int i = 0; i < nopt; i++) begin
			n = $urandom_range(0, 10);
			lens.push_back(n);
			size += 4 + pad4(n);
		end
		put32(IDB_TYPE_WORD);
		put32(20 + size);
		put16(16'($urandom));
		put16(16'($urandom));
		put32($urandom);
		foreach (lens[i]) begin
			put16(16'($urandom_range(1, 65535)));
			put16(16'(lens[i]));
			repeat (pad4(lens[i])) put8(8'($urandom));
		end
		if (end_opt) put32(0);
		repeat (tail) put8(8'($urandom));
		put32(20 + size);
	endtask

	task automatic add_other(input logic [31:0] kind_word, input int body);
		put32(kind_word);
		put32(12 + body);
		repeat (body) put8(8'($urandom));
		put32(12 + body);
	endtask

	task automatic add_random_block();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 6) begin
			add_packet($urandom_range(0, 9) == 0 ? $urandom_range(60, 200) :
				$urandom_range(0, 24), $urandom_range(0, 1) ? 0 : 4 * $urandom_range(1, 3), 1'b0);
		end else if (pick < 9) begin
			add_iface($urandom_range(0, 3), 1'($urandom_range(0, 1)), $urandom_range(0, 3));
		end else begin
			add_other($urandom_range(0, 1) ? 32'd3 : SHB_TYPE_WORD, $urandom_range(0, 9));
		end
	endtask

	task automatic end_stream(input int how);
		case (how)
			0: put_eos();
			1: begin
				repeat ($urandom_range(1, 3)) put8(8'($urandom));
				put_eos();
			end
			2: begin
				put32(EPB_TYPE_WORD);
				put32(40);
				put32($urandom);
				put_eos();
			end
			3: add_packet($urandom_range(1, 9), 0, 1'b1);
			4: begin
				put32(EPB_TYPE_WORD);
				put32($urandom_range(0, 11));
			end
			5: begin
				put32(EPB_TYPE_WORD);
				put32(32 + pad4(cap_limit + 1));
				put32($urandom);
				put32($urandom);
				put32($urandom);
				put32(cap_limit + 1);
				put32($urandom);
			end
			default: begin
				put32(IDB_TYPE_WORD);
				put32(28);
				put32($urandom);
				put32($urandom);
				put16(16'd2);
				put16(16'd8);
			end
		endcase
		repeat (6) put8(8'($urandom));
		put_eos();
	endtask

	initial begin
		model_reset();
		big_endian = 1'($urandom_range(0, 1));
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		apb_write(24'hFFFFFF);
		add_section(4 * $urandom_range(0, 2));
		add_packet(0, 0, 1'b0);
		add_packet(1, 0, 1'b0);
		add_packet(5, 8, 1'b0);
		add_iface(0, 1'b0, 0);
		add_iface(2, 1'b1, 3);
		add_iface(1, 1'b0, 2);
		add_other(32'd3, 0);
		add_other(32'hFFFFFFFF, 5);
		drain();

		apb_write(24'd0);
		add_packet(0, 4, 1'b0);
		add_iface(1, 1'b1, 0);
		add_packet(0, 0, 1'b0);
		drain();

		apb_write(24'd8);
		add_packet(8, 0, 1'b0);
		add_packet(7, 0, 1'b0);
		drain();

		apb_write(24'($urandom_range(200, 16777215)));
		while (bytes_sent < 1300) add_random_block();
		drain();

		quiet = 1;
		apb_write(24'($urandom_range(64, 4096)));
		repeat (3) add_random_block();
		end_stream($urandom_range(0, 6));
		drain();
		repeat (10) @(posedge clk);

		$display("covered %0d file bytes: %0d packet bytes, %0d packets, %0d interfaces",
			bytes_sent, n_data, n_pkt, n_iface);
		$display("byte order %s, stream ended with status %0d",
			big_endian ? "big" : "little", final_status);
		if (errors == 0) begin
			$display("PASS pcapng_block_stream_parser");
		end else begin
			$display("FAIL pcapng_block_stream_parser");
		end
		$finish;
	end
endmodule
